// ===== design/ilut_pkg.sv =====
// Shared types, codes and constants for the interpolating lookup table.
// No dependencies.
`timescale 1ns / 1ps

package ilut_pkg;

  localparam int VW = 32;
  localparam int DW = 10;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_RESCALE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  localparam logic [2:0] REG_X_MIN     = 3'd0;
  localparam logic [2:0] REG_X_MAX     = 3'd1;
  localparam logic [2:0] REG_INV_STEP  = 3'd2;
  localparam logic [2:0] REG_DIVISIONS = 3'd3;
  localparam logic [2:0] REG_MODE      = 3'd4;

  localparam logic signed [VW-1:0] SCALE_ONE = 32'sd65536;

  typedef struct packed {
    logic signed [VW-1:0] x_min;
    logic signed [VW-1:0] x_max;
    logic [31:0]          inv_step;
    logic [DW-1:0]        divisions;
    logic                 lookup_mode;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LK_DIFF, S_LK_MUL, S_LK_ADDR, S_LK_LO, S_LK_HI, S_LK_SUM,
    S_WR, S_RD_ISSUE, S_RD_CAP, S_RS_CHECK, S_RS_ISSUE, S_RS_MUL, S_RS_START,
    S_RS_WAIT, S_RS_WRITE, S_FINISH
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_LOAD, DP_LK_DIFF, DP_LK_MUL, DP_LK_ADDR, DP_LK_LO, DP_LK_HI, DP_LK_SUM,
    DP_WR, DP_RD_ISSUE, DP_RD_CAP, DP_RS_CHECK, DP_RS_ISSUE, DP_RS_MUL, DP_RS_START,
    DP_RS_WRITE, DP_OUT
  } step_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       direct;
    logic       data_zero;
    logic       last;
    logic       div_done;
  } dp_status_t;

endpackage

// ===== design/ilut_if.sv =====
// Request and result channel interfaces.
// Depends on ilut_pkg.
`timescale 1ns / 1ps

interface ilut_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [ilut_pkg::VW-1:0]    x_value;
  logic [ilut_pkg::DW-1:0]           entry_index;
  logic signed [ilut_pkg::VW-1:0]    data_value;

  modport source (output valid, command, x_value, entry_index, data_value, input ready);
  modport sink (input valid, command, x_value, entry_index, data_value, output ready);
endinterface

interface ilut_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ilut_pkg::VW-1:0]    result_value;
  logic [1:0]                        status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ===== design/ilut_div.sv =====
// Unsigned 64 / 32 restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module ilut_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [32:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;

  assign rem_sh = {rem[31:0], quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem      <= rem_sh - {1'b0, divisor};
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/ilut_ctrl.sv =====
// Sequencing state machine and result-valid flag.
// Depends on ilut_pkg.
`timescale 1ns / 1ps

module ilut_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ilut_pkg::step_t      step,
  input  ilut_pkg::dp_status_t stat
);

  ilut_pkg::state_t state, state_next;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilut_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ilut_pkg::S_IDLE:     if (in_valid) state_next = ilut_pkg::S_DISPATCH;
      ilut_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          ilut_pkg::CMD_LOOKUP: state_next = ilut_pkg::S_LK_DIFF;
          ilut_pkg::CMD_WRITE:  state_next = ilut_pkg::S_WR;
          ilut_pkg::CMD_READ:   state_next = ilut_pkg::S_RD_ISSUE;
          default:              state_next = ilut_pkg::S_RS_CHECK;
        endcase
      end
      ilut_pkg::S_LK_DIFF:  state_next = ilut_pkg::S_LK_MUL;
      ilut_pkg::S_LK_MUL:   state_next = ilut_pkg::S_LK_ADDR;
      ilut_pkg::S_LK_ADDR:  state_next = ilut_pkg::S_LK_LO;
      ilut_pkg::S_LK_LO:    state_next = stat.direct ? ilut_pkg::S_FINISH : ilut_pkg::S_LK_HI;
      ilut_pkg::S_LK_HI:    state_next = ilut_pkg::S_LK_SUM;
      ilut_pkg::S_LK_SUM:   state_next = ilut_pkg::S_FINISH;
      ilut_pkg::S_WR:       state_next = ilut_pkg::S_FINISH;
      ilut_pkg::S_RD_ISSUE: state_next = ilut_pkg::S_RD_CAP;
      ilut_pkg::S_RD_CAP:   state_next = ilut_pkg::S_FINISH;
      ilut_pkg::S_RS_CHECK:
        state_next = stat.data_zero ? ilut_pkg::S_FINISH : ilut_pkg::S_RS_ISSUE;
      ilut_pkg::S_RS_ISSUE: state_next = ilut_pkg::S_RS_MUL;
      ilut_pkg::S_RS_MUL:   state_next = ilut_pkg::S_RS_START;
      ilut_pkg::S_RS_START: state_next = ilut_pkg::S_RS_WAIT;
      ilut_pkg::S_RS_WAIT:  if (stat.div_done) state_next = ilut_pkg::S_RS_WRITE;
      ilut_pkg::S_RS_WRITE:
        state_next = stat.last ? ilut_pkg::S_FINISH : ilut_pkg::S_RS_ISSUE;
      ilut_pkg::S_FINISH:   if (slot_free) state_next = ilut_pkg::S_IDLE;
      default:              state_next = ilut_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    step     = ilut_pkg::DP_NONE;
    unique case (state)
      ilut_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) step = ilut_pkg::DP_LOAD;
      end
      ilut_pkg::S_LK_DIFF:  step = ilut_pkg::DP_LK_DIFF;
      ilut_pkg::S_LK_MUL:   step = ilut_pkg::DP_LK_MUL;
      ilut_pkg::S_LK_ADDR:  step = ilut_pkg::DP_LK_ADDR;
      ilut_pkg::S_LK_LO:    step = ilut_pkg::DP_LK_LO;
      ilut_pkg::S_LK_HI:    step = ilut_pkg::DP_LK_HI;
      ilut_pkg::S_LK_SUM:   step = ilut_pkg::DP_LK_SUM;
      ilut_pkg::S_WR:       step = ilut_pkg::DP_WR;
      ilut_pkg::S_RD_ISSUE: step = ilut_pkg::DP_RD_ISSUE;
      ilut_pkg::S_RD_CAP:   step = ilut_pkg::DP_RD_CAP;
      ilut_pkg::S_RS_CHECK: step = ilut_pkg::DP_RS_CHECK;
      ilut_pkg::S_RS_ISSUE: step = ilut_pkg::DP_RS_ISSUE;
      ilut_pkg::S_RS_MUL:   step = ilut_pkg::DP_RS_MUL;
      ilut_pkg::S_RS_START: step = ilut_pkg::DP_RS_START;
      ilut_pkg::S_RS_WRITE: step = ilut_pkg::DP_RS_WRITE;
      ilut_pkg::S_FINISH:   if (slot_free) step = ilut_pkg::DP_OUT;
      default:              step = ilut_pkg::DP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step == ilut_pkg::DP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ilut_pkg::S_DISPATCH))
    else $error("request accepted but controller did not start");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    (state == ilut_pkg::S_FINISH && slot_free) |=> out_valid)
    else $error("result not presented after finish");

  a_div_done_writes: assert property (@(posedge clk) disable iff (rst)
    (state == ilut_pkg::S_RS_WAIT && stat.div_done) |=> (state == ilut_pkg::S_RS_WRITE))
    else $error("divider result not written back");

endmodule

// ===== design/ilut_datapath.sv =====
// Table memory, lookup arithmetic, rescale loop and result register.
// Depends on ilut_pkg and ilut_div.
`timescale 1ns / 1ps

module ilut_datapath #(
  parameter int TABLE_DEPTH = ilut_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ilut_pkg::cfg_t                   cfg,
  input  ilut_pkg::step_t                  step,
  output ilut_pkg::dp_status_t             stat,
  input  logic [1:0]                       in_command,
  input  logic signed [ilut_pkg::VW-1:0]   in_x,
  input  logic [ilut_pkg::DW-1:0]          in_index,
  input  logic signed [ilut_pkg::VW-1:0]   in_data,
  output logic signed [ilut_pkg::VW-1:0]   result_value,
  output logic [1:0]                       status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = ilut_pkg::DW;
  localparam int VW = ilut_pkg::VW;

  logic signed [VW-1:0] mem [TABLE_DEPTH];
  logic signed [VW-1:0] rd_data;
  logic [AW-1:0]        ram_addr;
  logic                 ram_we;
  logic signed [VW-1:0] ram_wdata;

  logic [1:0]           cmd_q;
  logic signed [VW-1:0] x_q;
  logic [DW-1:0]        idx_q;
  logic signed [VW-1:0] data_q;
  logic [31:0]          diff_q;
  logic                 le_q, ge_q;
  logic [63:0]          pos_q;
  logic [AW-1:0]        addr_q;
  logic                 direct_q;
  logic [15:0]          frac_q;
  logic signed [VW-1:0] lo_q;
  logic signed [49:0]   lprod_q;
  logic signed [63:0]   prod_q;
  logic [DW-1:0]        i_q;
  logic signed [VW-1:0] scale_q;
  logic signed [VW-1:0] res_q;
  logic [1:0]           stat_q;

  logic [DW-1:0]        div_eff, d;
  logic                 in_range;
  logic [32:0]          round_idx, lk_sel;
  logic                 lk_direct;
  logic signed [32:0]   span;
  logic signed [34:0]   lsum;
  logic signed [VW-1:0] lsum_sat;
  logic                 div_done;
  logic [63:0]          quot;
  logic                 neg;
  logic [63:0]          dvd_mag;
  logic [31:0]          dvs_mag;
  logic signed [VW-1:0] q_sat;

  always_comb begin
    div_eff = (cfg.divisions == '0) ? DW'(1) : cfg.divisions;
    if (32'(div_eff) > 32'(TABLE_DEPTH - 1)) d = DW'(TABLE_DEPTH - 1);
    else d = div_eff;
  end

  assign in_range = idx_q <= d;

  always_comb begin
    round_idx = {1'b0, pos_q[63:32]} + 33'(pos_q[31]);
    lk_sel    = 33'(d);
    lk_direct = 1'b1;
    if (le_q) begin
      lk_sel = '0;
    end else if (ge_q) begin
      lk_sel = 33'(d);
    end else if (!cfg.lookup_mode) begin
      lk_sel = (round_idx > 33'(d)) ? 33'(d) : round_idx;
    end else if ({1'b0, pos_q[63:32]} < 33'(d)) begin
      lk_sel    = {1'b0, pos_q[63:32]};
      lk_direct = 1'b0;
    end
  end

  assign span = 33'(rd_data) - 33'(lo_q);
  assign lsum = 35'(lo_q) + 35'(lprod_q >>> 16);
  always_comb begin
    if (lsum > 35'sd2147483647) lsum_sat = 32'sh7fffffff;
    else if (lsum < -35'sd2147483648) lsum_sat = 32'sh80000000;
    else lsum_sat = lsum[VW-1:0];
  end

  always_comb begin
    ram_addr  = '0;
    ram_we    = 1'b0;
    ram_wdata = q_sat;
    case (step)
      ilut_pkg::DP_LK_ADDR:  ram_addr = AW'(lk_sel);
      ilut_pkg::DP_LK_LO:    ram_addr = addr_q + AW'(1);
      ilut_pkg::DP_RD_ISSUE: ram_addr = AW'(idx_q);
      ilut_pkg::DP_WR: begin
        ram_addr  = AW'(idx_q);
        ram_we    = in_range;
        ram_wdata = data_q;
      end
      ilut_pkg::DP_RS_ISSUE: ram_addr = AW'(i_q);
      ilut_pkg::DP_RS_WRITE: begin
        ram_addr = AW'(i_q);
        ram_we   = 1'b1;
      end
      default: ram_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) mem[ram_addr] <= ram_wdata;
    rd_data <= mem[ram_addr];
  end

  assign neg     = prod_q[63] ^ scale_q[VW-1];
  assign dvd_mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  assign dvs_mag = scale_q[VW-1] ? 32'(-scale_q) : 32'(scale_q);

  always_comb begin
    if (neg) begin
      if (quot > 64'h8000_0000) q_sat = 32'sh80000000;
      else q_sat = -$signed(quot[VW-1:0]);
    end else begin
      if (quot > 64'h7fff_ffff) q_sat = 32'sh7fffffff;
      else q_sat = $signed(quot[VW-1:0]);
    end
  end

  ilut_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (step == ilut_pkg::DP_RS_START),
    .dividend (dvd_mag),
    .divisor  (dvs_mag),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q <= ilut_pkg::SCALE_ONE;
    end else if (step == ilut_pkg::DP_RS_WRITE && i_q == d) begin
      scale_q <= data_q;
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      ilut_pkg::DP_LOAD: begin
        cmd_q  <= in_command;
        x_q    <= in_x;
        idx_q  <= in_index;
        data_q <= in_data;
        stat_q <= ilut_pkg::STAT_OK;
      end
      ilut_pkg::DP_LK_DIFF: begin
        diff_q <= 32'(x_q - cfg.x_min);
        le_q   <= x_q <= cfg.x_min;
        ge_q   <= x_q >= cfg.x_max;
      end
      ilut_pkg::DP_LK_MUL:  pos_q <= diff_q * cfg.inv_step;
      ilut_pkg::DP_LK_ADDR: begin
        addr_q   <= AW'(lk_sel);
        direct_q <= lk_direct;
        frac_q   <= pos_q[31:16];
      end
      ilut_pkg::DP_LK_LO: begin
        lo_q  <= rd_data;
        res_q <= rd_data;
      end
      ilut_pkg::DP_LK_HI:  lprod_q <= 50'(span * $signed({1'b0, frac_q}));
      ilut_pkg::DP_LK_SUM: res_q <= lsum_sat;
      ilut_pkg::DP_WR: begin
        res_q  <= '0;
        stat_q <= in_range ? ilut_pkg::STAT_OK : ilut_pkg::STAT_RANGE;
      end
      ilut_pkg::DP_RD_CAP: begin
        res_q  <= in_range ? rd_data : '0;
        stat_q <= in_range ? ilut_pkg::STAT_OK : ilut_pkg::STAT_RANGE;
      end
      ilut_pkg::DP_RS_CHECK: begin
        i_q    <= '0;
        res_q  <= scale_q;
        stat_q <= (data_q == '0) ? ilut_pkg::STAT_ZERO : ilut_pkg::STAT_OK;
      end
      ilut_pkg::DP_RS_MUL:   prod_q <= 64'(rd_data * data_q);
      ilut_pkg::DP_RS_WRITE: begin
        i_q   <= i_q + DW'(1);
        res_q <= data_q;
      end
      ilut_pkg::DP_OUT: begin
        result_value <= res_q;
        status       <= stat_q;
      end
      default: ;
    endcase
  end

  assign stat.cmd       = cmd_q;
  assign stat.direct    = direct_q;
  assign stat.data_zero = data_q == '0;
  assign stat.last      = i_q == d;
  assign stat.div_done  = div_done;

endmodule

// ===== design/interpolating_lookup_table.sv =====
// Interpolating lookup table, top level: configuration registers on an APB-style
// port, controller and datapath. Depends on ilut_pkg, ilut_if, ilut_ctrl, ilut_datapath.
//
// Requests arrive on in_ch (valid/ready); each carries a command: lookup, entry
// write, entry read or rescale. Exactly one result leaves on out_ch per request.
// One request is processed at a time; in_ch.ready is high only while idle.
// A direct lookup takes one read of the single-port table and one multiply; with
// interpolation it takes two reads plus two multiplies. A rescale visits entries 0
// through divisions (read as 1 when zero, capped at TABLE_DEPTH-1), each through the
// bit-serial divider; a rescale with zero data is rejected without visiting any.
// The next request is accepted the cycle after the result is loaded, also
// while that result still waits in the output register.
// If out_ch.ready is low, the finished result is held and the controller waits
// until the output register is free.
// Reset (rst, synchronous) restores register defaults and the scale of 1.0 and
// clears all control state; the table contents are undefined until written.
// Registers lie at byte offsets 4*i: x_min, x_max, inv_step, divisions,
// lookup_mode; write them only while no request is outstanding.
`timescale 1ns / 1ps

module interpolating_lookup_table #(
  parameter int TABLE_DEPTH = ilut_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ilut_in_if.sink     in_ch,
  ilut_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ilut_pkg::cfg_t       cfg;
  ilut_pkg::step_t      step;
  ilut_pkg::dp_status_t stat;
  logic [2:0]           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min       <= '0;
      cfg.x_max       <= 32'sd65536;
      cfg.inv_step    <= 32'd65536;
      cfg.divisions   <= ilut_pkg::DW'(1);
      cfg.lookup_mode <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ilut_pkg::REG_X_MIN:     cfg.x_min       <= pwdata;
        ilut_pkg::REG_X_MAX:     cfg.x_max       <= pwdata;
        ilut_pkg::REG_INV_STEP:  cfg.inv_step    <= pwdata;
        ilut_pkg::REG_DIVISIONS: cfg.divisions   <= pwdata[ilut_pkg::DW-1:0];
        ilut_pkg::REG_MODE:      cfg.lookup_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ilut_pkg::REG_X_MIN:     prdata = cfg.x_min;
      ilut_pkg::REG_X_MAX:     prdata = cfg.x_max;
      ilut_pkg::REG_INV_STEP:  prdata = cfg.inv_step;
      ilut_pkg::REG_DIVISIONS: prdata = 32'(cfg.divisions);
      ilut_pkg::REG_MODE:      prdata = 32'(cfg.lookup_mode);
      default:                 prdata = '0;
    endcase
  end

  ilut_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .step      (step),
    .stat      (stat)
  );

  ilut_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (step),
    .stat         (stat),
    .in_command   (in_ch.command),
    .in_x         (in_ch.x_value),
    .in_index     (in_ch.entry_index),
    .in_data      (in_ch.data_value),
    .result_value (out_ch.result_value),
    .status       (out_ch.status)
  );

endmodule
